[design/dsa_pkg.sv]
package dsa_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int PTR_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

  localparam int HEAP_W    = 11;
  localparam int ADDR_W    = 64;
  localparam int STRIDE_W  = 13;
  localparam int IDX_W     = 10;
  localparam int PROD_W    = STRIDE_W + IDX_W;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 144;
  localparam int OUT_DATA_W  = IDX_W + 2 * ADDR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_SIZE   = 2'd0,
    REG_CPU_BASE    = 2'd1,
    REG_GPU_BASE    = 2'd2,
    REG_SLOT_STRIDE = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_FIFO  = 2'd1,
    SRC_FRESH = 2'd2
  } slot_src_t;

endpackage

[design/dsa_ram.sv]
module dsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/descriptor_slot_allocator_unit.sv]
// Descriptor slot allocator. Each input word is either an allocate request (tuser 0) or a free
// request (tuser 1, slot index in tdata). Frees are queued in a first-in first-out free list
// (a free into a full list is dropped) and produce no output word; an allocate takes the oldest
// freed slot, otherwise the next slot never handed out, and returns the slot index with its
// host and device addresses (base plus stride times index, modulo 2^64). With no slot available
// it returns a word with tuser set and all data zero, and nothing changes. One word is accepted
// per cycle unless the output stalls; a result passes the free-list read, stride multiply and
// base add stages, and a waiting result does not block requests while stages behind it are
// empty. The free list is one single-port-write RAM with a registered read and needs no clearing
// after reset. Configuration is to be written only while idle; the unit does not enforce this.
module descriptor_slot_allocator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dsa_pkg::IN_TDATA_W-1:0]      in_tdata,   // free_index, zero fill
  input  logic                                in_tuser,   // mode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dsa_pkg::OUT_TDATA_W-1:0]     out_tdata,  // slot_index, cpu_address,
                                                          // gpu_address, zero fill
  output logic                                out_tuser,  // out_of_space
  input  logic                                cfg_we,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dsa_pkg::CFG_W-1:0]           cfg_wdata
);

  // Configuration registers
  logic [dsa_pkg::HEAP_W-1:0]   heap_size_r;
  logic [dsa_pkg::ADDR_W-1:0]   cpu_base_r;
  logic [dsa_pkg::ADDR_W-1:0]   gpu_base_r;
  logic [dsa_pkg::STRIDE_W-1:0] slot_stride_r;

  // Allocation state
  logic [dsa_pkg::CNT_W-1:0] next_fresh_r, next_fresh_nxt;
  logic [dsa_pkg::PTR_W-1:0] head_r, head_nxt;
  logic [dsa_pkg::PTR_W-1:0] tail_r, tail_nxt;
  logic [dsa_pkg::CNT_W-1:0] count_r, count_nxt;

  // Pipeline
  logic                       s1_v_r;
  dsa_pkg::slot_src_t         s1_src_r, s1_src_nxt;
  logic [dsa_pkg::IDX_W-1:0]  s1_fresh_r;
  logic                       s2_v_r;
  logic                       s2_oos_r;
  logic [dsa_pkg::IDX_W-1:0]  s2_idx_r;
  logic [dsa_pkg::PROD_W-1:0] s2_prod_r;
  logic                       out_v_r;
  logic                       out_oos_r;
  logic [dsa_pkg::IDX_W-1:0]  out_idx_r;
  logic [dsa_pkg::ADDR_W-1:0] out_cpu_r;
  logic [dsa_pkg::ADDR_W-1:0] out_gpu_r;

  logic                       out_ready;
  logic                       s2_ready;
  logic                       s1_ready;
  logic                       in_acc;
  logic                       is_free;
  logic                       ram_we;
  logic                       ram_re;
  logic [dsa_pkg::IDX_W-1:0]  ram_q;
  logic [dsa_pkg::CNT_W-1:0]  limit;
  logic [dsa_pkg::IDX_W-1:0]  s1_idx;
  logic [dsa_pkg::ADDR_W-1:0] prod_ext;

  assign out_ready = !out_v_r || out_tready;
  assign s2_ready  = !s2_v_r || out_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_tready = s1_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign is_free   = (dsa_pkg::mode_t'(in_tuser) == dsa_pkg::MODE_FREE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_size_r   <= dsa_pkg::HEAP_W'(1024);
      cpu_base_r    <= '0;
      gpu_base_r    <= '0;
      slot_stride_r <= dsa_pkg::STRIDE_W'(32);
    end else if (cfg_we) begin
      unique case (dsa_pkg::cfg_reg_t'(cfg_index))
        dsa_pkg::REG_HEAP_SIZE:   heap_size_r   <= cfg_wdata[dsa_pkg::HEAP_W-1:0];
        dsa_pkg::REG_CPU_BASE:    cpu_base_r    <= cfg_wdata;
        dsa_pkg::REG_GPU_BASE:    gpu_base_r    <= cfg_wdata;
        dsa_pkg::REG_SLOT_STRIDE: slot_stride_r <= cfg_wdata[dsa_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(heap_size_r) > 32'(dsa_pkg::MAX_SLOTS)) begin
      limit = dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS);
    end else begin
      limit = dsa_pkg::CNT_W'(heap_size_r);
    end
  end

  always_comb begin
    next_fresh_nxt = next_fresh_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    s1_src_nxt     = dsa_pkg::SRC_NONE;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    if (in_acc) begin
      if (is_free) begin
        if (count_r < dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS)) begin
          ram_we    = 1'b1;
          tail_nxt  = (tail_r == dsa_pkg::PTR_W'(dsa_pkg::MAX_SLOTS - 1)) ? '0 : tail_r + 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end else if (count_r != '0) begin
        ram_re     = 1'b1;
        head_nxt   = (head_r == dsa_pkg::PTR_W'(dsa_pkg::MAX_SLOTS - 1)) ? '0 : head_r + 1'b1;
        count_nxt  = count_r - 1'b1;
        s1_src_nxt = dsa_pkg::SRC_FIFO;
      end else if (next_fresh_r < limit) begin
        next_fresh_nxt = next_fresh_r + 1'b1;
        s1_src_nxt     = dsa_pkg::SRC_FRESH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_fresh_r <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
    end else begin
      next_fresh_r <= next_fresh_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
    end
  end

  dsa_ram #(
    .WIDTH (dsa_pkg::IDX_W),
    .DEPTH (dsa_pkg::MAX_SLOTS)
  ) u_free_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (in_tdata[dsa_pkg::IDX_W-1:0]),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_q)
  );

  always_comb begin
    case (s1_src_r)
      dsa_pkg::SRC_FIFO:  s1_idx = ram_q;
      dsa_pkg::SRC_FRESH: s1_idx = s1_fresh_r;
      default:            s1_idx = '0;
    endcase
  end

  assign prod_ext = dsa_pkg::ADDR_W'(s2_prod_r);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_acc && !is_free;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (out_ready) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_src_r   <= s1_src_nxt;
      s1_fresh_r <= dsa_pkg::IDX_W'(next_fresh_r);
    end
    if (s2_ready) begin
      s2_oos_r  <= (s1_src_r == dsa_pkg::SRC_NONE);
      s2_idx_r  <= s1_idx;
      s2_prod_r <= dsa_pkg::PROD_W'(slot_stride_r * s1_idx);
    end
    if (out_ready) begin
      out_oos_r <= s2_oos_r;
      out_idx_r <= s2_idx_r;
      out_cpu_r <= s2_oos_r ? '0 : cpu_base_r + prod_ext;
      out_gpu_r <= s2_oos_r ? '0 : gpu_base_r + prod_ext;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_oos_r;
  assign out_tdata  = {{(dsa_pkg::OUT_TDATA_W - dsa_pkg::OUT_DATA_W){1'b0}},
                       out_gpu_r, out_cpu_r, out_idx_r};

  // The free list never holds more entries than it has room for.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS))
    else $error("free list count overflow");

  // Head and tail meet only when the free list is empty or full.
  assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == tail_r) |-> (count_r == '0 || count_r == dsa_pkg::CNT_W'(dsa_pkg::MAX_SLOTS)))
    else $error("free list pointers disagree with count");

  // A request held in the first stage keeps its free-list read data.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_ready) |=> (s1_v_r && $stable(s1_src_r) &&
                               (s1_src_r != dsa_pkg::SRC_FIFO || $stable(ram_q))))
    else $error("first stage lost its data while stalled");

  // An exhausted heap reports all-zero data.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_oos_r) |-> (out_idx_r == '0 && out_cpu_r == '0 && out_gpu_r == '0))
    else $error("out-of-space result carries data");

endmodule

[verif/descriptor_slot_allocator_unit_tb.sv]
`timescale 1ns / 100ps

module descriptor_slot_allocator_unit_tb;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                       out_of_space;
    logic [dsa_pkg::ADDR_W-1:0] gpu_address;
    logic [dsa_pkg::ADDR_W-1:0] cpu_address;
    logic [dsa_pkg::IDX_W-1:0]  slot_index;
  } slot_grant_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [dsa_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [dsa_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            cfg_we;
  logic [dsa_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [dsa_pkg::CFG_W-1:0]       cfg_wdata;

  logic [dsa_pkg::HEAP_W-1:0]   heap_cfg;
  logic [dsa_pkg::ADDR_W-1:0]   cpu_base_cfg;
  logic [dsa_pkg::ADDR_W-1:0]   gpu_base_cfg;
  logic [dsa_pkg::STRIDE_W-1:0] stride_cfg;
  int                           fresh_next;
  logic [dsa_pkg::IDX_W-1:0]    free_list[$];
  logic [dsa_pkg::IDX_W-1:0]    granted_slots[$];
  slot_grant_t                  grants_due[$];

  int tx_idle_pct  = 36;
  int rx_idle_pct  = 36;
  int rx_hold_left = 0;
  int failures     = 0;
  int n_alloc      = 0;
  int n_free       = 0;
  int n_dropped    = 0;
  int n_exhausted  = 0;
  int n_results    = 0;
  int n_settings   = 0;

  descriptor_slot_allocator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  task automatic predict_request(input dsa_pkg::mode_t mode,
                                 input logic [dsa_pkg::IDX_W-1:0] idx);
    slot_grant_t               grant;
    logic [dsa_pkg::IDX_W-1:0] slot;
    int                        limit;
    bit                        found;
    if (mode == dsa_pkg::MODE_FREE) begin
      n_free++;
      if (free_list.size() < dsa_pkg::MAX_SLOTS) begin
        free_list.push_back(idx);
      end else begin
        n_dropped++;
      end
    end else begin
      n_alloc++;
      grant = '0;
      found = 1'b1;
      limit = (heap_cfg > dsa_pkg::MAX_SLOTS) ? dsa_pkg::MAX_SLOTS : int'(heap_cfg);
      if (free_list.size() > 0) begin
        slot = free_list.pop_front();
      end else if (fresh_next < limit) begin
        slot = dsa_pkg::IDX_W'(fresh_next);
        fresh_next++;
      end else begin
        found = 1'b0;
      end
      if (found) begin
        grant.slot_index  = slot;
        grant.cpu_address = cpu_base_cfg + 64'(stride_cfg) * 64'(slot);
        grant.gpu_address = gpu_base_cfg + 64'(stride_cfg) * 64'(slot);
        granted_slots.push_back(slot);
      end else begin
        grant.out_of_space = 1'b1;
        n_exhausted++;
      end
      grants_due.push_back(grant);
    end
  endtask

  task automatic send_request(input dsa_pkg::mode_t mode,
                              input logic [dsa_pkg::IDX_W-1:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {{(dsa_pkg::IN_TDATA_W-dsa_pkg::IDX_W){1'b0}}, idx};
    do @(posedge clk); while (!in_tready);
    predict_request(mode, idx);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input dsa_pkg::cfg_reg_t reg_id,
                           input logic [dsa_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= reg_id;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (reg_id)
      dsa_pkg::REG_HEAP_SIZE:   heap_cfg     = value[dsa_pkg::HEAP_W-1:0];
      dsa_pkg::REG_CPU_BASE:    cpu_base_cfg = value;
      dsa_pkg::REG_GPU_BASE:    gpu_base_cfg = value;
      dsa_pkg::REG_SLOT_STRIDE: stride_cfg   = value[dsa_pkg::STRIDE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [dsa_pkg::CFG_W-1:0] heap,
                                input logic [dsa_pkg::CFG_W-1:0] cpu,
                                input logic [dsa_pkg::CFG_W-1:0] gpu,
                                input logic [dsa_pkg::CFG_W-1:0] stride);
    write_reg(dsa_pkg::REG_HEAP_SIZE, heap);
    write_reg(dsa_pkg::REG_CPU_BASE, cpu);
    write_reg(dsa_pkg::REG_GPU_BASE, gpu);
    write_reg(dsa_pkg::REG_SLOT_STRIDE, stride);
    n_settings++;
  endtask

  function automatic logic [dsa_pkg::IDX_W-1:0] pick_free_index();
    int k;
    logic [dsa_pkg::IDX_W-1:0] idx;
    if (granted_slots.size() > 0 && $urandom_range(99) < 75) begin
      k = $urandom_range(granted_slots.size() - 1);
      idx = granted_slots[k];
      granted_slots.delete(k);
    end else begin
      idx = dsa_pkg::IDX_W'($urandom);
    end
    return idx;
  endfunction

  task automatic random_traffic(input int count, input int alloc_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < alloc_pct) begin
        send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
      end else begin
        send_request(dsa_pkg::MODE_FREE, pick_free_index());
      end
    end
  endtask

  task automatic test_directed();
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    send_request(dsa_pkg::MODE_FREE, 10'd0);
    send_request(dsa_pkg::MODE_FREE, 10'd1023);
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    // The same slot returned twice is handed out twice.
    send_request(dsa_pkg::MODE_FREE, 10'd5);
    send_request(dsa_pkg::MODE_FREE, 10'd5);
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    send_request(dsa_pkg::MODE_FREE, 10'h2AA);
    send_request(dsa_pkg::MODE_FREE, 10'h155);
    drain_results();
    // Heap limit below the fresh counter: only queued slots can be handed out.
    write_reg(dsa_pkg::REG_HEAP_SIZE, 64'd2);
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    drain_results();
    write_reg(dsa_pkg::REG_HEAP_SIZE, 64'd0);
    send_request(dsa_pkg::MODE_FREE, 10'd7);
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    drain_results();
    write_reg(dsa_pkg::REG_HEAP_SIZE, 64'd1024);
  endtask

  task automatic test_config_sweep();
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: apply_settings(64'd2047, '1, {32'hFFFF_FFFF, $urandom}, 64'd8191);
        1: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          apply_settings(64'd1024, 64'd0, 64'd0, 64'd0);
        end
        2: apply_settings(64'd1, {$urandom, $urandom}, {$urandom, $urandom}, 64'd4096);
        3: apply_settings({$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom});
        default: apply_settings(64'd0, {$urandom, $urandom}, '1, 64'(32'($urandom_range(8191))));
      endcase
      random_traffic(60, 60);
      drain_results();
      tx_idle_pct = 36;
      rx_idle_pct = 36;
    end
  endtask

  task automatic test_backpressure();
    apply_settings(64'd1024, {$urandom, $urandom}, {$urandom, $urandom}, 64'd32);
    tx_idle_pct  = 0;
    rx_hold_left = HOLD_CYCLES;
    random_traffic(60, 80);
    tx_idle_pct = 36;
    drain_results();
  endtask

  task automatic test_heap_exhaustion();
    int stop;
    stop = (fresh_next + 24 > dsa_pkg::MAX_SLOTS) ? dsa_pkg::MAX_SLOTS : fresh_next + 24;
    apply_settings(64'(stop), {$urandom, $urandom}, {$urandom, $urandom}, 64'd32);
    while (fresh_next < stop) begin
      random_traffic(1, 95);
    end
    while (free_list.size() > 0) begin
      send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    end
    repeat (6) send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    send_request(dsa_pkg::MODE_FREE, pick_free_index());
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    drain_results();
  endtask

  task automatic test_full_free_list();
    while (free_list.size() < dsa_pkg::MAX_SLOTS) begin
      send_request(dsa_pkg::MODE_FREE, dsa_pkg::IDX_W'($urandom));
    end
    repeat (3) send_request(dsa_pkg::MODE_FREE, dsa_pkg::IDX_W'($urandom));
    repeat (16) send_request(dsa_pkg::MODE_ALLOC, dsa_pkg::IDX_W'($urandom));
    drain_results();
  endtask

  initial begin
    heap_cfg     = 11'd1024;
    cpu_base_cfg = '0;
    gpu_base_cfg = '0;
    stride_cfg   = 13'd32;
    fresh_next   = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= dsa_pkg::REG_HEAP_SIZE;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_heap_exhaustion();
    test_full_free_list();
    $display("Sent %0d requests: %0d allocations, %0d frees, %0d of them into a full list.",
             n_alloc + n_free, n_alloc, n_free, n_dropped);
    $display("Checked %0d results over %0d register settings, %0d of them out of space.",
             n_results, n_settings, n_exhausted);
    if (failures == 0 && grants_due.size() == 0) begin
      $display("PASS descriptor_slot_allocator_unit");
    end else begin
      $display("FAIL descriptor_slot_allocator_unit");
    end
    $finish;
  end

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_tready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    slot_grant_t got;
    slot_grant_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      got.slot_index   = out_tdata[dsa_pkg::IDX_W-1:0];
      got.cpu_address  = out_tdata[dsa_pkg::IDX_W +: dsa_pkg::ADDR_W];
      got.gpu_address  = out_tdata[dsa_pkg::IDX_W+dsa_pkg::ADDR_W +: dsa_pkg::ADDR_W];
      got.out_of_space = out_tuser;
      if (grants_due.size() == 0) begin
        report_failure($sformatf("Unexpected word: slot %0d cpu %h gpu %h out_of_space %b",
                                 got.slot_index, got.cpu_address, got.gpu_address,
                                 got.out_of_space));
      end else begin
        want = grants_due.pop_front();
        if (got !== want) begin
          report_failure($sformatf({"Mismatch on word %0d: expected slot %0d cpu %h gpu %h ",
                                    "out_of_space %b, got slot %0d cpu %h gpu %h out_of_space %b"},
                                   n_results, want.slot_index, want.cpu_address,
                                   want.gpu_address, want.out_of_space, got.slot_index,
                                   got.cpu_address, got.gpu_address, got.out_of_space));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timeout: no word accepted for %0d cycles.", QUIET_LIMIT);
    $display("FAIL descriptor_slot_allocator_unit");
    $finish;
  end

endmodule
